// ===== sv/uuidtpc_pkg.sv =====
// Shared types and constants for the UUID text parser and checker.
package uuidtpc_pkg;

   localparam logic [5:0] UUID_TEXT_LEN = 6'd36;
   localparam logic [5:0] POS_SAT       = 6'd37;

   localparam logic [63:0] VER_XOR  = 64'hFFFF_FFFF_FFFF_4FFF;
   localparam logic [63:0] VER_MASK = 64'h0000_0000_0000_F000;
   localparam logic [63:0] VAR_XOR  = 64'h8FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VAR_MASK = 64'hC000_0000_0000_0000;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
   localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
   localparam logic [2:0] ST_BAD_HYPHEN = 3'd3;
   localparam logic [2:0] ST_NOT_RFC    = 3'd4;

   localparam logic [1:0] FE_NONE   = 2'd0;
   localparam logic [1:0] FE_CHAR   = 2'd1;
   localparam logic [1:0] FE_HYPHEN = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] id_high;
      logic [63:0] id_low;
      logic        id_is_v4;
   } rsp_type;

   typedef struct packed {
      logic       nib_valid;
      logic [3:0] nib;
      logic       dash;
      logic       hyphen_pos;
      logic       is_ver4;
      logic       is_variant;
   } class_type;

endpackage

// ===== sv/uuidtpc_char_class.sv =====
// Character classifier: hex value, hyphen and version/variant markers.
module uuidtpc_char_class (
   input  logic [7:0]             char_code,
   input  logic [5:0]             position,
   output uuidtpc_pkg::class_type cls
);
   import uuidtpc_pkg::*;

   always_comb begin
      cls.nib_valid = 1'b1;
      cls.nib       = 4'd0;
      if (char_code >= 8'h30 && char_code <= 8'h39) begin
         cls.nib = 4'(char_code - 8'h30);
      end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
         cls.nib = 4'(char_code - 8'h57);
      end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
         cls.nib = 4'(char_code - 8'h37);
      end else begin
         cls.nib_valid = 1'b0;
      end
      cls.dash       = (char_code == 8'h2D);
      cls.hyphen_pos = (position == 6'd8) || (position == 6'd13) ||
                       (position == 6'd18) || (position == 6'd23);
      cls.is_ver4    = (char_code == 8'h34);
      cls.is_variant = (char_code == 8'h38) || (char_code == 8'h39) ||
                       (char_code == 8'h61) || (char_code == 8'h62) ||
                       (char_code == 8'h41) || (char_code == 8'h42);
   end

endmodule

// ===== sv/uuid_text_parse_check.sv =====
// UUID text parser: takes one character per word and reports once per string. A character
// can be taken in every cycle while the input is not stalled; a string's result appears in
// the output register in the cycle after its final character. The input stalls only while a
// result still waits in that register and the output side is not taking it. The stored ID
// is replaced only by a string that passes every check, and reset sets it to zero.
module uuid_text_parse_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  uuidtpc_pkg::req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output uuidtpc_pkg::rsp_type rsp_word
);
   import uuidtpc_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  err_ff, err_in;
   logic        ver_ff, ver_in;
   logic        var_ff, var_in;
   logic [63:0] acc_hi_ff, acc_hi_in;
   logic [63:0] acc_lo_ff, acc_lo_in;
   logic [63:0] id_hi_ff, id_hi_in;
   logic [63:0] id_lo_ff, id_lo_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_word_ff, rsp_word_in;
   class_type   cls;
   logic        accept;
   logic [2:0]  status;

   uuidtpc_char_class u_class (
      .char_code (req_word.char_code),
      .position  (pos_ff),
      .cls       (cls)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      err_in = err_ff;
      if (err_ff == FE_NONE) begin
         if (!cls.nib_valid && !cls.dash) begin
            err_in = FE_CHAR;
         end else if (cls.hyphen_pos != cls.dash) begin
            err_in = FE_HYPHEN;
         end
      end
      ver_in = (pos_ff == 6'd14) ? cls.is_ver4 : ver_ff;
      var_in = (pos_ff == 6'd19) ? cls.is_variant : var_ff;
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      if (cls.nib_valid) begin
         acc_hi_in = {acc_hi_ff[59:0], acc_lo_ff[63:60]};
         acc_lo_in = {acc_lo_ff[59:0], cls.nib};
      end
      pos_in = (pos_ff < POS_SAT) ? pos_ff + 6'd1 : pos_ff;

      // Length takes precedence, then the first character fault, then the markers.
      if (pos_in != UUID_TEXT_LEN) begin
         status = ST_BAD_LENGTH;
      end else begin
         case (err_in)
            FE_NONE:   status = (ver_in && var_in) ? ST_OK : ST_NOT_RFC;
            FE_CHAR:   status = ST_BAD_CHAR;
            FE_HYPHEN: status = ST_BAD_HYPHEN;
            default:   status = ST_BAD_CHAR;
         endcase
      end

      id_hi_in = (status == ST_OK) ? acc_hi_in : id_hi_ff;
      id_lo_in = (status == ST_OK) ? acc_lo_in : id_lo_ff;

      rsp_word_in.status   = status;
      rsp_word_in.id_high  = id_hi_in;
      rsp_word_in.id_low   = id_lo_in;
      rsp_word_in.id_is_v4 = (((id_hi_in ^ VER_XOR) & VER_MASK) == 64'd0) &&
                             (((id_lo_in ^ VAR_XOR) & VAR_MASK) == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 6'd0;
         err_ff       <= FE_NONE;
         ver_ff       <= 1'b0;
         var_ff       <= 1'b0;
         acc_hi_ff    <= 64'd0;
         acc_lo_ff    <= 64'd0;
         id_hi_ff     <= 64'd0;
         id_lo_ff     <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_word.last_char) begin
               pos_ff    <= 6'd0;
               err_ff    <= FE_NONE;
               ver_ff    <= 1'b0;
               var_ff    <= 1'b0;
               acc_hi_ff <= 64'd0;
               acc_lo_ff <= 64'd0;
               id_hi_ff  <= id_hi_in;
               id_lo_ff  <= id_lo_in;
            end else begin
               pos_ff    <= pos_in;
               err_ff    <= err_in;
               ver_ff    <= ver_in;
               var_ff    <= var_in;
               acc_hi_ff <= acc_hi_in;
               acc_lo_ff <= acc_lo_in;
            end
         end
         if (accept && req_word.last_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.last_char) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== sv/uuidtpc_checker.sv =====
// Port-level checker for the UUID text parser, bound to the top level.
module uuidtpc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input uuidtpc_pkg::req_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input uuidtpc_pkg::rsp_type rsp_word
);
   import uuidtpc_pkg::*;

   logic [63:0] seen_hi_ff;
   logic [63:0] seen_lo_ff;

   // Tracks the ID carried by the most recent delivered word.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_hi_ff <= 64'd0;
         seen_lo_ff <= 64'd0;
      end else if (rsp_valid && rsp_ready) begin
         seen_hi_ff <= rsp_word.id_high;
         seen_lo_ff <= rsp_word.id_low;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_fail_keeps_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |->
         rsp_word.id_high == seen_hi_ff && rsp_word.id_low == seen_lo_ff)
      else $error("failed string altered the stored ID");

   a_ok_is_v4: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_OK |-> rsp_word.id_is_v4)
      else $error("accepted ID lacks version 4 markers");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= ST_NOT_RFC)
      else $error("status code out of range");

   // A final character always leaves a result word waiting in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.last_char |=> rsp_valid)
      else $error("final character produced no result word");

endmodule

bind uuid_text_parse_check uuidtpc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
